FILE: rtl/pfrgb_pkg.sv
// Shared types, constants and lookup tables for the pixel format to RGB converter.
package pfrgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int CH_W      = FRAC_BITS + 1;           // 0..1.0 inclusive
  localparam int TERM_W    = CH_W + 1;                // signed chroma term
  localparam int SUM_W     = CH_W + 3;                // signed channel sum
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE / 2;

  localparam int BYTE_W       = 8;
  localparam int FMT_W        = 4;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = FMT_W;
  localparam int IN_TDATA_W   = 4 * BYTE_W;
  localparam int OUT_TDATA_W  = ((3 * CH_W + 7) / 8) * 8;

  // BT.709 coefficients in Q16
  localparam longint COEF_RV = 103206;
  localparam longint COEF_GU = 12275;
  localparam longint COEF_GV = 30677;
  localparam longint COEF_BU = 121609;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGBA = 4'd0,
    FMT_BGRA = 4'd1,
    FMT_BGRX = 4'd2,
    FMT_NV12 = 4'd3,
    FMT_I420 = 4'd4,
    FMT_I40A = 4'd5,
    FMT_I422 = 4'd6,
    FMT_YUY2 = 4'd7,
    FMT_UYVY = 4'd8,
    FMT_YVYU = 4'd9
  } pixel_format_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT = 4'd0,
    REG_FULL_RANGE   = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [FMT_W-1:0] pixel_format;
    logic             full_range_mode;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef logic [255:0][CH_W-1:0]   chan_lut_t;
  typedef logic [255:0][TERM_W-1:0] term_lut_t;

  // round(c * ONE / 255)
  function automatic chan_lut_t build_scale_lut();
    chan_lut_t lut;
    longint    v;
    for (int i = 0; i < 256; i++) begin
      v      = (longint'(i) * ONE + 127) / 255;
      lut[i[7:0]] = CH_W'(v);
    end
    return lut;
  endfunction

  // limited-range luma: floor at 16, round((Y - 16) * ONE / 219)
  function automatic chan_lut_t build_luma_lut();
    chan_lut_t lut;
    longint    v;
    for (int i = 0; i < 256; i++) begin
      if (i < 16) v = 0;
      else        v = (longint'(i - 16) * ONE + 109) / 219;
      lut[i[7:0]] = CH_W'(v);
    end
    return lut;
  endfunction

  // coef * (scaled chroma - 0.5), rounded half away from zero
  function automatic term_lut_t build_term_lut(input longint coef);
    term_lut_t lut;
    longint    u;
    longint    mag;
    longint    p;
    for (int i = 0; i < 256; i++) begin
      u   = (longint'(i) * ONE + 127) / 255 - HALF;
      mag = (u < 0) ? -u : u;
      p   = (coef * mag + 32768) >>> 16;
      lut[i[7:0]] = TERM_W'((u < 0) ? -p : p);
    end
    return lut;
  endfunction

  localparam chan_lut_t SCALE_LUT = build_scale_lut();
  localparam chan_lut_t LUMA_LUT  = build_luma_lut();
  localparam term_lut_t RV_LUT    = build_term_lut(COEF_RV);
  localparam term_lut_t GU_LUT    = build_term_lut(COEF_GU);
  localparam term_lut_t GV_LUT    = build_term_lut(COEF_GV);
  localparam term_lut_t BU_LUT    = build_term_lut(COEF_BU);

  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(ONE);

  function automatic logic signed [SUM_W-1:0] ext_chan(input logic [CH_W-1:0] c);
    return $signed({{(SUM_W-CH_W){1'b0}}, c});
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_term(input logic [TERM_W-1:0] t);
    return $signed({{(SUM_W-TERM_W){t[TERM_W-1]}}, t});
  endfunction

  function automatic logic [CH_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v < 0)          r = '0;
    else if (v > ONE_S) r = CH_W'(ONE);
    else                r = v[CH_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/pixel_format_to_rgb_converter.sv
// Top level of the pixel format to RGB converter: stream handshake and pipeline registers.
//
// Usage:
//   Slave stream s_axis carries the raw bytes fetched for one source pixel;
//   s_axis_tuser holds the source column parity. Master stream m_axis
//   returns red, green and blue in Q12 (4096 = 1.0), one transfer out for
//   each transfer in, in order.
//   pixel_format and full_range_mode are written through cfg_we_i/cfg_idx_i/
//   cfg_data_i (index 0 format, 1 range, other indexes ignored); write them
//   only while no pixel is in flight.
// Timing:
//   Two register stages: input register, then conversion logic feeding the
//   result register; m_axis_tvalid rises once the pixel reaches the result
//   register. One pixel per cycle while the output is not stalled, limited
//   only by the table lookups, adds and saturation between the two registers.
// Reset:
//   rst_ni low empties both stages and sets format RGBA, limited range.
// Backpressure:
//   When m_axis_tready is low the result holds; the input stage still takes
//   one more pixel, then s_axis_tready drops until the output drains.
module pixel_format_to_rgb_converter
  import pfrgb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input pixel stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: byte_zero[7:0], byte_one[15:8], byte_two[23:16], byte_three[31:24]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: odd_column[0]
  input  logic                   s_axis_tuser,
  // output RGB stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: red[12:0], green[25:13], blue[38:26], zero pad above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cfg_t cfg;
  rgb_t rgb;

  // stage 1: input register
  logic                  in_valid_q, in_valid_d;
  logic [IN_TDATA_W-1:0] in_data_q;
  logic                  in_odd_q;
  // stage 2: result register
  logic                  out_valid_q, out_valid_d;
  rgb_t                  out_rgb_q;

  logic advance;   // stage 1 moves into stage 2
  logic in_xfer;

  pfrgb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
      in_valid_d  = 1'b0;
    end
    if (in_xfer) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= s_axis_tdata;
      in_odd_q  <= s_axis_tuser;
    end
    if (advance && in_valid_q) begin
      out_rgb_q <= rgb;
    end
  end

  pfrgb_convert u_convert (
    .cfg_i        (cfg),
    .byte_zero_i  (in_data_q[0*BYTE_W +: BYTE_W]),
    .byte_one_i   (in_data_q[1*BYTE_W +: BYTE_W]),
    .byte_two_i   (in_data_q[2*BYTE_W +: BYTE_W]),
    .byte_three_i (in_data_q[3*BYTE_W +: BYTE_W]),
    .odd_column_i (in_odd_q),
    .rgb_o        (rgb)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-3*CH_W){1'b0}},
                          out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red};

endmodule

FILE: rtl/pfrgb_cfg.sv
// Configuration register file: pixel format and luma range.
module pfrgb_cfg
  import pfrgb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [FMT_W-1:0] fmt_q, fmt_d;
  logic             full_q, full_d;

  always_comb begin
    fmt_d  = fmt_q;
    full_d = full_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == REG_PIXEL_FORMAT) fmt_d  = cfg_data_i[FMT_W-1:0];
      if (cfg_idx_i == REG_FULL_RANGE)   full_d = cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FMT_RGBA;
      full_q <= 1'b0;
    end else begin
      fmt_q  <= fmt_d;
      full_q <= full_d;
    end
  end

  assign cfg_o.pixel_format    = fmt_q;
  assign cfg_o.full_range_mode = full_q;

endmodule

FILE: rtl/pfrgb_convert.sv
// Combinational byte swizzle, BT.709 YUV to RGB conversion and saturation.
module pfrgb_convert
  import pfrgb_pkg::*;
(
  input  cfg_t              cfg_i,
  input  logic [BYTE_W-1:0] byte_zero_i,
  input  logic [BYTE_W-1:0] byte_one_i,
  input  logic [BYTE_W-1:0] byte_two_i,
  input  logic [BYTE_W-1:0] byte_three_i,
  input  logic              odd_column_i,
  output rgb_t              rgb_o
);

  typedef enum logic [1:0] {
    PATH_ZERO,
    PATH_RGB,
    PATH_YUV
  } path_e;

  path_e             path;
  logic [BYTE_W-1:0] r_byte, g_byte, b_byte;
  logic [BYTE_W-1:0] y_byte, u_byte, v_byte;
  logic [CH_W-1:0]   y_val;
  logic signed [SUM_W-1:0] y_s, r_sum, g_sum, b_sum;

  // byte routing per format
  always_comb begin
    path   = PATH_ZERO;
    r_byte = byte_zero_i;
    g_byte = byte_one_i;
    b_byte = byte_two_i;
    y_byte = byte_zero_i;
    u_byte = byte_one_i;
    v_byte = byte_two_i;
    unique case (cfg_i.pixel_format)
      FMT_RGBA: path = PATH_RGB;
      FMT_BGRA, FMT_BGRX: begin
        path   = PATH_RGB;
        r_byte = byte_two_i;
        b_byte = byte_zero_i;
      end
      FMT_NV12, FMT_I420, FMT_I40A, FMT_I422: path = PATH_YUV;
      FMT_YUY2: begin
        path   = PATH_YUV;
        y_byte = odd_column_i ? byte_two_i : byte_zero_i;
        v_byte = byte_three_i;
      end
      FMT_UYVY: begin
        path   = PATH_YUV;
        y_byte = odd_column_i ? byte_three_i : byte_one_i;
        u_byte = byte_zero_i;
      end
      FMT_YVYU: begin
        path   = PATH_YUV;
        y_byte = odd_column_i ? byte_two_i : byte_zero_i;
        u_byte = byte_three_i;
        v_byte = byte_one_i;
      end
      default: path = PATH_ZERO;
    endcase
  end

  assign y_val = cfg_i.full_range_mode ? SCALE_LUT[y_byte] : LUMA_LUT[y_byte];
  assign y_s   = ext_chan(y_val);
  assign r_sum = y_s + ext_term(RV_LUT[v_byte]);
  assign g_sum = y_s - ext_term(GU_LUT[u_byte]) - ext_term(GV_LUT[v_byte]);
  assign b_sum = y_s + ext_term(BU_LUT[u_byte]);

  always_comb begin
    unique case (path)
      PATH_RGB: begin
        rgb_o.red   = SCALE_LUT[r_byte];
        rgb_o.green = SCALE_LUT[g_byte];
        rgb_o.blue  = SCALE_LUT[b_byte];
      end
      PATH_YUV: begin
        rgb_o.red   = saturate(r_sum);
        rgb_o.green = saturate(g_sum);
        rgb_o.blue  = saturate(b_sum);
      end
      default: rgb_o = '0;
    endcase
  end

endmodule

FILE: rtl/pfrgb_checker.sv
// Port-level checks for the pixel format to RGB converter, bound to the top level.
module pfrgb_checker
  import pfrgb_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [CH_W-1:0] ONE_C = CH_W'(ONE);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped while stalled");

  // every channel saturates to 0..1.0
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[CH_W-1:0] <= ONE_C) &&
                      (m_axis_tdata[2*CH_W-1:CH_W] <= ONE_C) &&
                      (m_axis_tdata[3*CH_W-1:2*CH_W] <= ONE_C))
    else $error("channel above 1.0");

  // pad bits of the result stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:3*CH_W] == '0)
    else $error("nonzero pad bits in result");

  // an accepted pixel moves from the input register to the output when the receiver is ready
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted pixel did not reach the output");

endmodule

bind pixel_format_to_rgb_converter pfrgb_checker u_pfrgb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/pixel_format_to_rgb_converter_tb.sv
// Self-checking stream testbench for the pixel format to RGB converter.
`timescale 1ns / 100ps

module pixel_format_to_rgb_converter_tb;
  import pfrgb_pkg::*;

  // Q16 BT.709 factors used by the local color model
  localparam longint K_RED_V   = 103206;
  localparam longint K_GREEN_U = 12275;
  localparam longint K_GREEN_V = 30677;
  localparam longint K_BLUE_U  = 121609;
  localparam int     UNIT      = 1 << FRAC_BITS;

  // format codes past the supported list; they must yield black
  localparam logic [FMT_W-1:0]     FMT_FIRST_UNSUPPORTED = 4'd10;
  localparam logic [FMT_W-1:0]     FMT_LAST_UNSUPPORTED  = 4'd15;
  // register indexes past the list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SPARE  = 4'd15;

  localparam int CYCLE_LIMIT = 200000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: byte_zero[7:0], byte_one[15:8], byte_two[23:16], byte_three[31:24]
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // tuser: odd_column[0]
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: red[12:0], green[25:13], blue[38:26], zero pad above
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // model copy of the two registers
  logic [FMT_W-1:0] cur_format     = FMT_RGBA;
  logic             cur_full_range = 1'b0;

  rgb_t rgb_expected_q[$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  // idle/stall odds out of 100, changed per traffic phase
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  pixel_format_to_rgb_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Color model
  // ---------------------------------------------------------------------------

  // byte -> round(c * 1.0 / 255)
  function automatic longint byte_to_unit(input logic [7:0] c);
    return (longint'(c) * UNIT + 127) / 255;
  endfunction

  // Q16 factor times signed chroma, ties rounded away from zero
  function automatic longint chroma_product(input longint coef, input longint x);
    longint mag;
    longint p;
    mag = (x < 0) ? -x : x;
    p   = (coef * mag + 32768) >>> 16;
    return (x < 0) ? -p : p;
  endfunction

  function automatic logic [CH_W-1:0] clamp_unit(input longint v);
    if (v < 0) return '0;
    if (v > UNIT) return CH_W'(UNIT);
    return CH_W'(v);
  endfunction

  function automatic rgb_t luma_chroma_pixel(input logic [7:0] yb, ub, vb);
    rgb_t   px;
    longint y;
    longint u;
    longint v;
    u = byte_to_unit(ub) - UNIT / 2;
    v = byte_to_unit(vb) - UNIT / 2;
    // limited range: 16..235 stretched to 0..1, black floor below 16
    if (cur_full_range) y = byte_to_unit(yb);
    else if (yb < 16)   y = 0;
    else                y = (longint'(yb - 16) * UNIT + 109) / 219;
    px.red   = clamp_unit(y + chroma_product(K_RED_V, v));
    px.green = clamp_unit(y - chroma_product(K_GREEN_U, u) - chroma_product(K_GREEN_V, v));
    px.blue  = clamp_unit(y + chroma_product(K_BLUE_U, u));
    return px;
  endfunction

  function automatic rgb_t predict_rgb(input logic [7:0] b0, b1, b2, b3, input logic odd);
    rgb_t px;
    px = '0;
    case (cur_format)
      FMT_RGBA: begin
        px.red   = CH_W'(byte_to_unit(b0));
        px.green = CH_W'(byte_to_unit(b1));
        px.blue  = CH_W'(byte_to_unit(b2));
      end
      FMT_BGRA, FMT_BGRX: begin
        px.red   = CH_W'(byte_to_unit(b2));
        px.green = CH_W'(byte_to_unit(b1));
        px.blue  = CH_W'(byte_to_unit(b0));
      end
      FMT_NV12, FMT_I420, FMT_I40A, FMT_I422: px = luma_chroma_pixel(b0, b1, b2);
      // packed 4:2:2: parity picks the luma of the pair
      FMT_YUY2: px = luma_chroma_pixel(odd ? b2 : b0, b1, b3);
      FMT_UYVY: px = luma_chroma_pixel(odd ? b3 : b1, b0, b2);
      FMT_YVYU: px = luma_chroma_pixel(odd ? b2 : b0, b3, b1);
      default:  px = '0;
    endcase
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Single-cycle register write; the model follows at once since writes
  // only happen with the pipe empty.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_PIXEL_FORMAT)    cur_format     = data;
    else if (idx == REG_FULL_RANGE) cur_full_range = data[0];
  endtask

  // One input transfer. tvalid is left high on return so a following call
  // in the same step can chain without a bubble; callers that stop sending
  // must lower it via wait_drained.
  task automatic send_pixel(input logic [7:0] b0, b1, b2, b3, input logic odd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b3, b2, b1, b0};
    s_axis_tuser  <= odd;
    do @(posedge clk_i); while (!s_axis_tready);
    rgb_expected_q.push_back(predict_rgb(b0, b1, b2, b3, odd));
  endtask

  // Stop sending and wait for every outstanding pixel; queue is sampled on
  // the falling edge to stay clear of the checker's pops.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (rgb_expected_q.size() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Mostly uniform, with the byte extremes mixed in often
  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // nothing written yet: RGBA, limited range
  task automatic test_reset_defaults();
    send_pixel(8'h40, 8'hFF, 8'h00, 8'h99, 1'b1);
    wait_drained();
  endtask

  task automatic test_packed_rgb();
    write_register(REG_PIXEL_FORMAT, FMT_RGBA);
    send_pixel(8'h00, 8'hFF, 8'h80, 8'h5A, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h01, 8'hFF, 1'b1);
    wait_drained();
    write_register(REG_PIXEL_FORMAT, FMT_BGRA);
    send_pixel(8'h12, 8'hFE, 8'h00, 8'h00, 1'b0);
    wait_drained();
    // padding byte must not leak into any channel
    write_register(REG_PIXEL_FORMAT, FMT_BGRX);
    send_pixel(8'hFF, 8'h7F, 8'h00, 8'hC3, 1'b1);
    wait_drained();
  endtask

  task automatic test_planar_yuv();
    write_register(REG_FULL_RANGE, 4'h0);
    write_register(REG_PIXEL_FORMAT, FMT_NV12);
    send_pixel(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);   // luma below 16, chroma extremes
    wait_drained();
    write_register(REG_PIXEL_FORMAT, FMT_I420);
    send_pixel(8'h10, 8'h80, 8'h80, 8'hFF, 1'b1);   // black point, neutral chroma
    wait_drained();
    write_register(REG_PIXEL_FORMAT, FMT_I40A);
    send_pixel(8'hEB, 8'hFF, 8'h00, 8'h55, 1'b0);   // white point
    wait_drained();
    write_register(REG_PIXEL_FORMAT, FMT_I422);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'hAA, 1'b1);   // luma above 235 saturates
    wait_drained();
    write_register(REG_FULL_RANGE, 4'h1);
    write_register(REG_PIXEL_FORMAT, FMT_NV12);
    send_pixel(8'hFF, 8'h80, 8'h80, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_packed_422();
    write_register(REG_FULL_RANGE, 4'h0);
    write_register(REG_PIXEL_FORMAT, FMT_YUY2);
    send_pixel(8'h0A, 8'h3C, 8'hC8, 8'hEB, 1'b0);
    send_pixel(8'h0A, 8'h3C, 8'hC8, 8'hEB, 1'b1);
    wait_drained();
    write_register(REG_PIXEL_FORMAT, FMT_UYVY);
    send_pixel(8'h0A, 8'h3C, 8'hC8, 8'hEB, 1'b0);
    send_pixel(8'h0A, 8'h3C, 8'hC8, 8'hEB, 1'b1);
    wait_drained();
    write_register(REG_PIXEL_FORMAT, FMT_YVYU);
    send_pixel(8'h0A, 8'h3C, 8'hC8, 8'hEB, 1'b0);
    send_pixel(8'h0A, 8'h3C, 8'hC8, 8'hEB, 1'b1);
    wait_drained();
  endtask

  task automatic test_unsupported_formats();
    write_register(REG_PIXEL_FORMAT, FMT_FIRST_UNSUPPORTED);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_drained();
    write_register(REG_PIXEL_FORMAT, FMT_LAST_UNSUPPORTED);
    send_pixel(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
    wait_drained();
  endtask

  // writes to indexes past the list must leave both registers alone
  task automatic test_spare_index();
    write_register(REG_PIXEL_FORMAT, FMT_BGRA);
    write_register(CFG_FIRST_SPARE, 4'hF);
    write_register(CFG_LAST_SPARE, 4'h0);
    send_pixel(8'h20, 8'h90, 8'hF0, 8'h01, 1'b1);
    wait_drained();
  endtask

  // Four handshake modes, each over several random register settings
  task automatic test_random_traffic();
    int mode;
    int phase;
    int n;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (phase = 0; phase < 6; phase++) begin
        write_register(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(15)));
        // upper data bits are don't-care for the range flag
        write_register(REG_FULL_RANGE, CFG_DATA_W'($urandom_range(15)));
        if ($urandom_range(3) == 0)
          write_register(CFG_IDX_W'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE)),
                         CFG_DATA_W'($urandom_range(15)));
        for (n = 0; n < 19; n++)
          send_pixel(random_byte(), random_byte(), random_byte(), random_byte(),
                     1'($urandom_range(1)));
        wait_drained();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and output backpressure
  // ---------------------------------------------------------------------------

  task automatic check_channel(input string name, input logic [CH_W-1:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    rgb_t got;
    rgb_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = rgb_t'(m_axis_tdata[3*CH_W-1:0]);
      if (rgb_expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        mismatch_count++;
      end else begin
        want = rgb_expected_q.pop_front();
        check_channel("red", want.red, got.red);
        check_channel("green", want.green, got.green);
        check_channel("blue", want.blue, got.blue);
        if (m_axis_tdata[OUT_TDATA_W-1:3*CH_W] !== '0) begin
          $display("%0t: tdata pad mismatch, expected 0, got %0h", $time,
                   m_axis_tdata[OUT_TDATA_W-1:3*CH_W]);
          mismatch_count++;
        end
      end
    end
    // sampled value above is the one the DUT saw; pick the next one now
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hard stop if the handshake ever hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_defaults();
    test_packed_rgb();
    test_planar_yuv();
    test_packed_422();
    test_unsupported_formats();
    test_spare_index();
    test_random_traffic();

    // let any stray extra result surface past the pipeline
    wait_drained();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && rgb_expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
